// ===== hw/rtl/rom_bank_window_mapper_core_macros.svh =====
// Assertion macros shared by the bank window mapper RTL.
// Included by the top level; depends on nothing else.
`ifndef ROM_BANK_WINDOW_MAPPER_CORE_MACROS_SVH
`define ROM_BANK_WINDOW_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RBWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RBWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rbwm_pkg.sv =====
// Shared types and constants for the bank window mapper.
// Used by rbwm_map and rom_bank_window_mapper_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rbwm_pkg;

   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned OFFSET_W = 18;
   localparam int unsigned WIN_W    = 14;

   // Number of banks fitted on the EPROM board.
   localparam logic [7:0] EPROM_BANKS = 8'd14;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   localparam logic [OFFSET_W-1:0] ROM_HIGH_BASE = 18'h08000;

   typedef enum logic [2:0] {
      TGT_VRAM  = 3'd0,
      TGT_EPROM = 3'd1,
      TGT_ROM   = 3'd2,
      TGT_BLANK = 3'd3,
      TGT_OUT   = 3'd4
   } target_type;

   typedef struct packed {
      target_type          target;
      logic [OFFSET_W-1:0] phys_offset;
   } map_result_type;

   // Main ROM base for the banked modes; k selects 0x20, 0x40 or 0x60.
   function automatic logic [OFFSET_W-1:0] rom_bank_base(input logic [1:0] k,
                                                         input logic       low);
      logic [OFFSET_W-1:0] base;
      case (k)
         2'd0:    base = low ? 18'h14000 : 18'h18000;
         2'd1:    base = low ? 18'h1c000 : 18'h20000;
         2'd2:    base = low ? 18'h24000 : 18'h28000;
         default: base = '0;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rom_bank_window_mapper_core.sv =====
// Bank select register and CPU window translation, top level.
// Depends on rbwm_pkg, rbwm_map and rom_bank_window_mapper_core_macros.svh.
//
// Usage: the request channel carries one transaction per access. With req_mode
// low it writes req_write_data into the bank select register and produces no
// response. With req_mode high it translates req_cpu_address and produces one
// response: rsp_target names the memory and rsp_phys_offset the byte offset.
// A request is taken into an input register, translated by short logic and
// held in the response register, where a read's answer waits; one transaction
// can be accepted every cycle while req_stall is low. A write changes the
// mapping for every read accepted after it.
// Reset (synchronous, active high) empties both registers and sets the bank
// select to zero, the video RAM mapping. While rsp_stall holds a waiting
// response, a write still completes and a read waits in the input register;
// req_stall rises only when that input register cannot move on.
`timescale 1ns / 1ps
`default_nettype none
`include "rom_bank_window_mapper_core_macros.svh"

module rom_bank_window_mapper_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [rbwm_pkg::ADDR_W-1:0]   req_cpu_address,
   input  wire logic [rbwm_pkg::DATA_W-1:0]   req_write_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_target,
   output logic [rbwm_pkg::OFFSET_W-1:0]      rsp_phys_offset
);
   import rbwm_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_mode_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [DATA_W-1:0]   s1_data_ff;
   logic [DATA_W-1:0]   bank_ff, bank_in;
   logic                rsp_valid_ff, rsp_valid_in;
   map_result_type      rsp_result_ff;
   map_result_type      map_result;
   logic                out_free;
   logic                s1_go;
   logic                req_take;

   rbwm_map u_map (
      .bank_select (bank_ff),
      .cpu_address (s1_addr_ff),
      .result      (map_result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A write leaves the input register without needing the response register.
   assign s1_go     = s1_valid_ff && ((s1_mode_ff == MODE_WRITE) || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
      bank_in      = bank_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_go && (s1_mode_ff == MODE_WRITE)) begin
         bank_in = s1_data_ff;
      end
      if (s1_go && (s1_mode_ff == MODE_READ)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bank_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_ff      <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_mode;
         s1_addr_ff <= req_cpu_address;
         s1_data_ff <= req_write_data;
      end
      if (s1_go && (s1_mode_ff == MODE_READ)) begin
         rsp_result_ff <= map_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target      = rsp_result_ff.target;
   assign rsp_phys_offset = rsp_result_ff.phys_offset;

   `RBWM_ASSERT_NOW(a_offset_zero_when_unbacked, clock, reset,
      rsp_valid_ff && (rsp_result_ff.target == TGT_BLANK || rsp_result_ff.target == TGT_OUT),
      rsp_result_ff.phys_offset == '0, "blank or unmapped response carries an offset")
   `RBWM_ASSERT_NEXT(a_write_updates_bank, clock, reset,
      s1_go && (s1_mode_ff == MODE_WRITE),
      bank_ff == $past(s1_data_ff), "bank select not taken from a completed write")
   `RBWM_ASSERT_NEXT(a_read_makes_response, clock, reset,
      s1_go && (s1_mode_ff == MODE_READ),
      rsp_valid_ff, "read left the input register without a response")

endmodule

`default_nettype wire

// ===== hw/rtl/rbwm_map.sv =====
// Combinational address translation for one CPU read.
// Depends on rbwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbwm_map (
   input  wire logic [rbwm_pkg::DATA_W-1:0] bank_select,
   input  wire logic [rbwm_pkg::ADDR_W-1:0] cpu_address,
   output rbwm_pkg::map_result_type         result
);
   import rbwm_pkg::*;

   logic              in_window;
   logic              low;
   logic [WIN_W-1:0]  win_offset;
   logic [OFFSET_W-1:0] win_ext;

   assign low        = (cpu_address[15:14] == 2'b01);
   assign in_window  = low || (cpu_address[15:14] == 2'b10);
   assign win_offset = cpu_address[WIN_W-1:0];
   assign win_ext    = OFFSET_W'(win_offset);

   always_comb begin
      result.target      = TGT_BLANK;
      result.phys_offset = '0;
      if (!in_window) begin
         result.target = TGT_OUT;
      end else if (bank_select[7]) begin
         if (!low) begin
            result.target      = TGT_ROM;
            result.phys_offset = ROM_HIGH_BASE + win_ext;
         end else if ({1'b0, bank_select[6:0]} < EPROM_BANKS) begin
            // Each EPROM bank is 16 KB, so the bank number sits above the window bits.
            result.target      = TGT_EPROM;
            result.phys_offset = OFFSET_W'({bank_select[6:0], win_offset});
         end
      end else begin
         case (bank_select[6:5])
            2'd0: begin
               if (low) begin
                  result.target      = TGT_VRAM;
                  result.phys_offset = win_ext;
               end else begin
                  result.target      = TGT_ROM;
                  result.phys_offset = ROM_HIGH_BASE + win_ext;
               end
            end
            default: begin
               result.target      = TGT_ROM;
               result.phys_offset = rom_bank_base(bank_select[6:5] - 2'd1, low) + win_ext;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
